/* src/button_release_trigger_qualifier_defines.svh */
// Assertion macros shared by the checker of the button release trigger qualifier.
// No dependencies; the checker pulls this in by include.
`ifndef BUTTON_RELEASE_TRIGGER_QUALIFIER_DEFINES_SVH
`define BUTTON_RELEASE_TRIGGER_QUALIFIER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRTQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BRTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/brtq_pkg.sv */
// Shared types, codes and constants of the button release trigger qualifier.
// No dependencies; every module of the block imports it.
package brtq_pkg;

  localparam int BUTTON_MAX           = 5;
  localparam int BUTTON_COUNT_DEFAULT = 5;
  localparam int LEVEL_W              = 5;
  localparam int TIME_W               = 32;
  localparam int MS_W                 = 16;
  localparam int COMBO_W              = 17;
  localparam int CFG_INDEX_W          = 3;
  localparam int CFG_DATA_W           = 16;
  localparam int BUTTON_ID_W          = 3;

  // Poll interval of the host, in milliseconds.
  localparam int POLL_PERIOD_MS = 50;

  localparam logic [MS_W-1:0]    HOLD_MAX              = 16'hFFFF;
  localparam logic [COMBO_W-1:0] COMBO_MAX             = 17'h1FFFF;
  localparam logic [MS_W-1:0]    DEFAULT_RESET_HOLD_MS = 16'd8000;
  localparam logic [MS_W-1:0]    WARN_LEAD_MS          = 16'd3000;
  localparam logic [MS_W-1:0]    MIN_PRESS_RESET       = 16'd200;
  localparam logic [MS_W-1:0]    RESET_HOLD_RESET      = 16'd8000;
  localparam logic [MS_W-1:0]    COOLDOWN_RESET        = 16'd2000;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_PRESS      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RESET_HOLD     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RESET_MASK     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COOLDOWN_FIRST = 3'd3;

  // Commands.
  localparam logic CMD_POLL  = 1'b0;
  localparam logic CMD_PRESS = 1'b1;

  // System states.
  localparam logic [1:0] SYS_NORMAL  = 2'd0;
  localparam logic [1:0] SYS_WARNING = 2'd2;

  // State requests.
  localparam logic [1:0] REQ_NONE          = 2'd0;
  localparam logic [1:0] REQ_NORMAL        = 2'd1;
  localparam logic [1:0] REQ_WARNING       = 2'd2;
  localparam logic [1:0] REQ_FACTORY_RESET = 2'd3;

  typedef struct packed {
    logic sample;     // poll accepted: follow the level
    logic evaluate;   // poll accepted with no combo held
    logic press;      // simulated press accepted
    logic sys_normal;
  } lane_ctrl_t;

  typedef struct packed {
    logic       held;     // reset combo is held on this item
    logic       stopped;  // factory reset already requested
    logic       stop;     // factory reset requested by this item
    logic [1:0] req;
  } combo_status_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] trigger_mask;
    logic [1:0]         state_request;
    logic               halted;
  } result_t;

endpackage

/* src/button_release_trigger_qualifier.sv */
// A result is registered in the output register, or in the skid entry while the output is stalled.
// The block takes one item per cycle while item_stall is low; a
// two-entry output stage (register plus skid) raises item_stall only when both are full.
// Reset (rst, synchronous): registers return to their defaults, buttons read released,
// hold and fire times clear, the combo and halt state clear; no clearing pass.
module button_release_trigger_qualifier import brtq_pkg::*; #(
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic                   command,
  input  logic [LEVEL_W-1:0]     levels,
  input  logic [TIME_W-1:0]      now_ms,
  input  logic [1:0]             system_state,
  input  logic [BUTTON_ID_W-1:0] wakeup_button,
  input  logic [BUTTON_ID_W-1:0] pressed_button,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [LEVEL_W-1:0]     trigger_mask,
  output logic [1:0]             state_request,
  output logic                   halted
);

  localparam logic [LEVEL_W-1:0] BTN_ALL = LEVEL_W'((1 << BUTTON_COUNT) - 1);

  logic [MS_W-1:0]    min_press_ms;
  logic [MS_W-1:0]    reset_hold_ms;
  logic [LEVEL_W-1:0] reset_mask;
  logic [MS_W-1:0]    cooldown [BUTTON_COUNT];

  logic               accept;
  logic               poll;
  logic               press;
  logic [LEVEL_W-1:0] pressed;
  logic [LEVEL_W-1:0] fire_mask;
  lane_ctrl_t         lane_ctrl;
  combo_status_t      combo;
  result_t            result_now;

  result_t            out_reg;
  logic               out_valid;
  result_t            skid;
  logic               skid_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_press_ms  <= MIN_PRESS_RESET;
      reset_hold_ms <= RESET_HOLD_RESET;
      reset_mask    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_PRESS:  min_press_ms  <= cfg_data;
        REG_RESET_HOLD: reset_hold_ms <= cfg_data;
        REG_RESET_MASK: reset_mask    <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_cooldown
    always_ff @(posedge clk) begin
      if (rst) begin
        cooldown[i] <= COOLDOWN_RESET;
      end else if (cfg_write && cfg_index == CFG_INDEX_W'(REG_COOLDOWN_FIRST + i)) begin
        cooldown[i] <= cfg_data;
      end
    end
  end

  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign poll       = accept && command == CMD_POLL && !combo.stopped;
  assign press      = accept && command == CMD_PRESS && !combo.stopped;
  assign pressed    = ~levels & BTN_ALL;

  brtq_combo u_combo (
    .clk           (clk),
    .rst           (rst),
    .en            (poll),
    .pressed       (pressed),
    .reset_mask    (reset_mask & BTN_ALL),
    .reset_hold_ms (reset_hold_ms),
    .system_state  (system_state),
    .status        (combo)
  );

  // While the combo is held, polls only make the lanes follow the levels.
  assign lane_ctrl.sample     = poll;
  assign lane_ctrl.evaluate   = poll && !combo.held;
  assign lane_ctrl.press      = press;
  assign lane_ctrl.sys_normal = system_state == SYS_NORMAL;

  for (genvar i = 0; i < BUTTON_MAX; i++) begin : g_lane
    if (i < BUTTON_COUNT) begin : g_used
      localparam logic [LEVEL_W-1:0] OTHER_BITS = ~LEVEL_W'(1 << i);
      brtq_lane #(
        .LANE_NUM (i + 1)
      ) u_lane (
        .clk            (clk),
        .rst            (rst),
        .ctrl           (lane_ctrl),
        .down           (pressed[i]),
        .others         (|(pressed & OTHER_BITS)),
        .now_ms         (now_ms),
        .wakeup_button  (wakeup_button),
        .pressed_button (pressed_button),
        .min_press_ms   (min_press_ms),
        .cooldown_limit (cooldown[i]),
        .fire           (fire_mask[i])
      );
    end else begin : g_unused
      assign fire_mask[i] = 1'b0;
    end
  end

  // Merge what the lanes and the combo tracker found.
  assign result_now.trigger_mask  = fire_mask;
  assign result_now.state_request = combo.req;
  assign result_now.halted        = combo.stopped || combo.stop;

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !result_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !result_stall) begin
      if (skid_valid) begin
        out_reg <= skid;
      end else if (accept) begin
        out_reg <= result_now;
      end
    end else if (accept) begin
      skid <= result_now;
    end
  end

  assign result_valid  = out_valid;
  assign trigger_mask  = out_reg.trigger_mask;
  assign state_request = out_reg.state_request;
  assign halted        = out_reg.halted;

endmodule

/* src/brtq_lane.sv */
// One button lane: hold time, previous level, cooldown and fire qualification.
// Depends on brtq_pkg.
module brtq_lane import brtq_pkg::*; #(
  parameter int LANE_NUM = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lane_ctrl_t             ctrl,
  input  logic                   down,
  input  logic                   others,
  input  logic [TIME_W-1:0]      now_ms,
  input  logic [BUTTON_ID_W-1:0] wakeup_button,
  input  logic [BUTTON_ID_W-1:0] pressed_button,
  input  logic [MS_W-1:0]        min_press_ms,
  input  logic [MS_W-1:0]        cooldown_limit,
  output logic                   fire
);

  localparam logic [BUTTON_ID_W-1:0] LANE_ID = BUTTON_ID_W'(LANE_NUM);

  logic              prev_down;
  logic [MS_W-1:0]   hold;
  logic [TIME_W-1:0] last_fire;

  logic              release_now;
  logic              holding;
  logic              qualified;
  logic              cooled;
  logic [MS_W:0]     hold_sum;
  logic [MS_W-1:0]   hold_next;
  logic [TIME_W-1:0] elapsed;

  // A release counts only when every other button is up as well.
  assign release_now = ctrl.evaluate && prev_down && !down && !others;
  assign holding     = ctrl.evaluate && down && !others;
  assign qualified   = (wakeup_button != LANE_ID) && (hold >= min_press_ms) && ctrl.sys_normal;
  assign elapsed     = now_ms - last_fire;
  assign cooled      = elapsed >= TIME_W'(cooldown_limit);
  assign hold_sum    = {1'b0, hold} + (MS_W+1)'(POLL_PERIOD_MS);
  assign hold_next   = hold_sum[MS_W] ? HOLD_MAX : hold_sum[MS_W-1:0];

  assign fire = (release_now && qualified && cooled) ||
                (ctrl.press && pressed_button == LANE_ID);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_down <= 1'b0;
      hold      <= '0;
      last_fire <= '0;
    end else begin
      if (ctrl.sample) begin
        prev_down <= down;
      end
      if (release_now) begin
        hold <= '0;
      end else if (holding) begin
        hold <= hold_next;
      end
      if (fire) begin
        last_fire <= now_ms;
      end
    end
  end

endmodule

/* src/brtq_combo.sv */
// Reset combo tracker: picks the two lowest marked buttons, times the hold and
// raises warning, return-to-normal and factory reset requests. Depends on brtq_pkg.
module brtq_combo import brtq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [LEVEL_W-1:0] pressed,
  input  logic [LEVEL_W-1:0] reset_mask,
  input  logic [MS_W-1:0]    reset_hold_ms,
  input  logic [1:0]         system_state,
  output combo_status_t      status
);

  logic               combo_active;
  logic [COMBO_W-1:0] combo_ms;
  logic               stopped;

  logic [LEVEL_W-1:0] first_bit;
  logic [LEVEL_W-1:0] rest_mask;
  logic [LEVEL_W-1:0] second_bit;
  logic               held;
  logic [MS_W-1:0]    reset_time;
  logic [MS_W-1:0]    warn_time;
  logic [COMBO_W-1:0] combo_base;
  logic [COMBO_W:0]   combo_sum;
  logic [COMBO_W-1:0] combo_ms_next;
  logic               over_reset;
  logic               over_warn;
  logic [1:0]         req;

  // Lowest set bit by two's complement, twice.
  assign first_bit  = reset_mask & (~reset_mask + LEVEL_W'(1));
  assign rest_mask  = reset_mask & ~first_bit;
  assign second_bit = rest_mask & (~rest_mask + LEVEL_W'(1));
  assign held = (first_bit != '0) && (second_bit != '0) &&
                ((pressed & first_bit) != '0) && ((pressed & second_bit) != '0);

  assign reset_time = (reset_hold_ms == '0) ? DEFAULT_RESET_HOLD_MS : reset_hold_ms;
  assign warn_time  = (reset_time > WARN_LEAD_MS) ? reset_time - WARN_LEAD_MS
                                                  : reset_time >> 1;

  assign combo_base    = combo_active ? combo_ms : '0;
  assign combo_sum     = {1'b0, combo_base} + (COMBO_W+1)'(POLL_PERIOD_MS);
  assign combo_ms_next = (combo_sum > (COMBO_W+1)'(COMBO_MAX)) ? COMBO_MAX
                                                              : combo_sum[COMBO_W-1:0];
  assign over_reset = combo_ms_next > COMBO_W'(reset_time);
  assign over_warn  = combo_ms_next > COMBO_W'(warn_time);

  always_comb begin
    req = REQ_NONE;
    if (en && held) begin
      if (over_reset) begin
        req = REQ_FACTORY_RESET;
      end else if (over_warn && system_state != SYS_WARNING) begin
        req = REQ_WARNING;
      end
    end else if (en && combo_active && system_state == SYS_WARNING) begin
      req = REQ_NORMAL;
    end
  end

  assign status.held    = held;
  assign status.stopped = stopped;
  assign status.stop    = en && held && over_reset;
  assign status.req     = req;

  always_ff @(posedge clk) begin
    if (rst) begin
      combo_active <= 1'b0;
      combo_ms     <= '0;
      stopped      <= 1'b0;
    end else if (en) begin
      if (held) begin
        combo_active <= 1'b1;
        combo_ms     <= combo_ms_next;
        if (over_reset) begin
          stopped <= 1'b1;
        end
      end else begin
        combo_active <= 1'b0;
        combo_ms     <= '0;
      end
    end
  end

endmodule

/* src/brtq_checker.sv */
// Port-level checker for the button release trigger qualifier, bound to the top level.
// Depends on brtq_pkg and button_release_trigger_qualifier_defines.svh.
`include "button_release_trigger_qualifier_defines.svh"

module brtq_checker import brtq_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_stall,
  input logic [LEVEL_W-1:0] trigger_mask,
  input logic [1:0]         state_request,
  input logic               halted
);

  // A halted block fires nothing and asks for nothing but the reset itself.
  `BRTQ_ASSERT_SAME(a_halted_quiet, clk, rst, result_valid && halted, trigger_mask == '0 && (state_request == REQ_NONE || state_request == REQ_FACTORY_RESET), "halted item fired or made a request")

  // Combo requests and button fires never come in the same item.
  `BRTQ_ASSERT_SAME(a_request_no_fire, clk, rst, result_valid && state_request != REQ_NONE, trigger_mask == '0, "state request together with a fire")

  `BRTQ_ASSERT_SAME(a_factory_halts, clk, rst, result_valid && state_request == REQ_FACTORY_RESET, halted, "factory reset without halt")

  // Once halted, every later item reports halted.
  `BRTQ_ASSERT_NEXT(a_halt_sticks, clk, rst, result_valid && !result_stall && halted, !result_valid || halted, "halt cleared without reset")

  `BRTQ_ASSERT_NEXT(a_stall_holds, clk, rst, result_valid && result_stall, result_valid && $stable(trigger_mask) && $stable(state_request) && $stable(halted), "stalled item changed")

endmodule

bind button_release_trigger_qualifier brtq_checker u_brtq_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .trigger_mask  (trigger_mask),
  .state_request (state_request),
  .halted        (halted)
);

/* tb/sv/brtq_tb_pkg.sv */
// Item type and the scoreboard class for the button release trigger qualifier bench.
// Depends on brtq_pkg for widths, register indexes, codes and reset values.
package brtq_tb_pkg;
  import brtq_pkg::*;

  localparam int REG_COUNT = 8;

  // System states that the block package leaves unnamed.
  localparam logic [1:0] SYS_BUSY  = 2'd1;
  localparam logic [1:0] SYS_OTHER = 2'd3;

  localparam logic [LEVEL_W-1:0] ALL_BUTTONS = LEVEL_W'((1 << BUTTON_COUNT_DEFAULT) - 1);

  typedef logic [MS_W:0]    hold_sum_t;
  typedef logic [COMBO_W:0] combo_sum_t;

  typedef struct packed {
    logic                   command;
    logic [LEVEL_W-1:0]     levels;
    logic [TIME_W-1:0]      now_ms;
    logic [1:0]             system_state;
    logic [BUTTON_ID_W-1:0] wakeup_button;
    logic [BUTTON_ID_W-1:0] pressed_button;
  } item_t;

  class trigger_tracker;
    logic [MS_W-1:0]    min_press;
    logic [MS_W-1:0]    reset_hold;
    logic [LEVEL_W-1:0] reset_mask;
    logic [MS_W-1:0]    cooldown [BUTTON_MAX];
    logic [LEVEL_W-1:0] prev_levels;
    logic [MS_W-1:0]    hold_ms [BUTTON_MAX];
    logic [TIME_W-1:0]  last_fire [BUTTON_MAX];
    logic               combo_on;
    logic [COMBO_W-1:0] combo_ms;
    logic               stopped;
    result_t            awaited_results [$];
    int                 errors, checked, fires, warnings, returns, halts;

    function new();
      min_press   = MIN_PRESS_RESET;
      reset_hold  = RESET_HOLD_RESET;
      reset_mask  = '0;
      prev_levels = ALL_BUTTONS;
      combo_on    = 1'b0;
      combo_ms    = '0;
      stopped     = 1'b0;
      for (int b = 0; b < BUTTON_MAX; b++) begin
        cooldown[b]  = COOLDOWN_RESET;
        hold_ms[b]   = '0;
        last_fire[b] = '0;
      end
      errors   = 0;
      checked  = 0;
      fires    = 0;
      warnings = 0;
      returns  = 0;
      halts    = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MIN_PRESS:  min_press = data;
        REG_RESET_HOLD: reset_hold = data;
        REG_RESET_MASK: reset_mask = data[LEVEL_W-1:0];
        default:        cooldown[idx - REG_COOLDOWN_FIRST] = data;
      endcase
    endfunction

    // The two lowest marked buttons form the reset combo.
    function void reset_pair(output logic [LEVEL_W-1:0] r0, output logic [LEVEL_W-1:0] r1);
      logic [LEVEL_W-1:0] m;
      m  = reset_mask & ALL_BUTTONS;
      r0 = m & (~m + 1'b1);
      m  = m & ~r0;
      r1 = m & (~m + 1'b1);
    endfunction

    function logic [MS_W-1:0] reset_time();
      return (reset_hold != '0) ? reset_hold : DEFAULT_RESET_HOLD_MS;
    endfunction

    function logic combo_held(logic [LEVEL_W-1:0] pressed);
      logic [LEVEL_W-1:0] r0, r1;
      reset_pair(r0, r1);
      return (r0 != '0) && (r1 != '0) && ((pressed & r0) != '0) && ((pressed & r1) != '0);
    endfunction

    // True when this poll would push the combo past the factory reset time.
    function logic would_halt(item_t it);
      combo_sum_t csum;
      if (stopped || it.command == CMD_PRESS || !combo_held(~it.levels & ALL_BUTTONS))
        return 1'b0;
      csum = (combo_on ? combo_sum_t'(combo_ms) : '0) + combo_sum_t'(POLL_PERIOD_MS);
      return csum > combo_sum_t'(reset_time());
    endfunction

    function void log_item(item_t it);
      result_t            want;
      logic [LEVEL_W-1:0] lv, pressed, bit_i;
      logic [MS_W-1:0]    rt, wt;
      combo_sum_t         csum;
      hold_sum_t          hsum;
      logic               alone, was_down, down;
      want = '0;
      lv      = it.levels & ALL_BUTTONS;
      pressed = ~lv & ALL_BUTTONS;
      if (stopped) begin
        want.halted = 1'b1;
      end else if (it.command == CMD_PRESS) begin
        if (it.pressed_button >= 1 && it.pressed_button <= BUTTON_COUNT_DEFAULT) begin
          last_fire[it.pressed_button - 1] = it.now_ms;
          want.trigger_mask = LEVEL_W'(1) << (it.pressed_button - 1);
        end
      end else begin
        if (combo_held(pressed)) begin
          rt = reset_time();
          wt = (rt > WARN_LEAD_MS) ? rt - WARN_LEAD_MS : rt >> 1;
          if (!combo_on) begin
            combo_on = 1'b1;
            combo_ms = '0;
          end
          csum = combo_sum_t'(combo_ms) + combo_sum_t'(POLL_PERIOD_MS);
          combo_ms = (csum > combo_sum_t'(COMBO_MAX)) ? COMBO_MAX : csum[COMBO_W-1:0];
          if (combo_ms > COMBO_W'(rt)) begin
            want.state_request = REQ_FACTORY_RESET;
            stopped = 1'b1;
          end else if (combo_ms > COMBO_W'(wt) && it.system_state != SYS_WARNING) begin
            want.state_request = REQ_WARNING;
          end
        end else begin
          if (combo_on) begin
            combo_on = 1'b0;
            combo_ms = '0;
            if (it.system_state == SYS_WARNING) want.state_request = REQ_NORMAL;
          end
          for (int i = 0; i < BUTTON_COUNT_DEFAULT; i++) begin
            bit_i    = LEVEL_W'(1) << i;
            alone    = (pressed & ~bit_i) == '0;
            was_down = (prev_levels & bit_i) == '0;
            down     = (pressed & bit_i) != '0;
            if (was_down && !down && alone) begin
              if (it.wakeup_button != BUTTON_ID_W'(i + 1) && hold_ms[i] >= min_press &&
                  it.system_state == SYS_NORMAL &&
                  (it.now_ms - last_fire[i]) >= TIME_W'(cooldown[i])) begin
                last_fire[i] = it.now_ms;
                want.trigger_mask = want.trigger_mask | bit_i;
              end
              hold_ms[i] = '0;
            end
            if (down && alone) begin
              hsum = hold_sum_t'(hold_ms[i]) + hold_sum_t'(POLL_PERIOD_MS);
              hold_ms[i] = (hsum > hold_sum_t'(HOLD_MAX)) ? HOLD_MAX : hsum[MS_W-1:0];
            end
          end
        end
        prev_levels = lv;
        want.halted = stopped;
      end
      if (want.trigger_mask != '0) fires++;
      if (want.state_request == REQ_WARNING) warnings++;
      if (want.state_request == REQ_NORMAL) returns++;
      if (want.state_request == REQ_FACTORY_RESET) halts++;
      awaited_results.push_back(want);
    endfunction

    function void compare_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        $error("result with no item outstanding: trigger_mask %h state_request %0d halted %0d",
               got.trigger_mask, got.state_request, got.halted);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      checked++;
      if (got.trigger_mask !== want.trigger_mask) begin
        $error("trigger_mask: expected %h, got %h", want.trigger_mask, got.trigger_mask);
        errors++;
      end
      if (got.state_request !== want.state_request) begin
        $error("state_request: expected %0d, got %0d", want.state_request, got.state_request);
        errors++;
      end
      if (got.halted !== want.halted) begin
        $error("halted: expected %0d, got %0d", want.halted, got.halted);
        errors++;
      end
    endfunction
  endclass

endpackage

/* tb/sv/tb_button_release_trigger_qualifier.sv */
// Top of the bench: drives polls, simulated presses and register writes into the qualifier
// and checks every result against trigger_tracker. Depends on brtq_pkg and brtq_tb_pkg.
module tb_button_release_trigger_qualifier;
  timeunit 1ns;
  timeprecision 1ps;
  import brtq_pkg::*;
  import brtq_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 135;
  localparam int HOLD_OFF_TICKS = 80;

  typedef enum {SEQ_HOLD, SEQ_COMBO, SEQ_OPEN, SEQ_NOISE} pattern_t;

  logic                   clk            = 1'b0;
  logic                   rst            = 1'b1;
  logic                   cfg_write      = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index      = '0;
  logic [CFG_DATA_W-1:0]  cfg_data       = '0;
  logic                   item_valid     = 1'b0;
  logic                   command        = CMD_POLL;
  logic [LEVEL_W-1:0]     levels         = '1;
  logic [TIME_W-1:0]      now_ms         = '0;
  logic [1:0]             system_state   = SYS_NORMAL;
  logic [BUTTON_ID_W-1:0] wakeup_button  = '0;
  logic [BUTTON_ID_W-1:0] pressed_button = BUTTON_ID_W'(1);
  logic                   result_stall   = 1'b0;
  logic                   item_stall;
  logic                   result_valid;
  logic [LEVEL_W-1:0]     trigger_mask;
  logic [1:0]             state_request;
  logic                   halted;

  trigger_tracker        tracker = new();
  logic [CFG_DATA_W-1:0] settings [REG_COUNT];
  logic [TIME_W-1:0]     clock_ms = '0;
  pattern_t              pattern = SEQ_OPEN;
  int                    pattern_left = 0;
  int                    pattern_button = 0;
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  bit                    hold_off_pending = 1'b0;
  int                    quiet_cycles = 0;
  int                    items_sent = 0;

  button_release_trigger_qualifier dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .command        (command),
    .levels         (levels),
    .now_ms         (now_ms),
    .system_state   (system_state),
    .wakeup_button  (wakeup_button),
    .pressed_button (pressed_button),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .trigger_mask   (trigger_mask),
    .state_request  (state_request),
    .halted         (halted)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        for (int k = 0; k < HOLD_OFF_TICKS; k++) begin
          result_stall <= 1'b1;
          @(posedge clk);
        end
      end
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      tracker.compare_result({trigger_mask, state_request, halted});
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles.", quiet_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic item_t item_of(logic cmd, logic [LEVEL_W-1:0] lv, logic [TIME_W-1:0] t,
                                    logic [1:0] sys, logic [BUTTON_ID_W-1:0] wake,
                                    logic [BUTTON_ID_W-1:0] pb);
    item_t it;
    it.command        = cmd;
    it.levels         = lv;
    it.now_ms         = t;
    it.system_state   = sys;
    it.wakeup_button  = wake;
    it.pressed_button = pb;
    return it;
  endfunction

  // Time mostly moves about one poll period on, with rare jumps anywhere and near the wrap.
  function automatic logic [TIME_W-1:0] advance_clock();
    int roll;
    roll = $urandom_range(99);
    if (roll < 2)
      clock_ms = $urandom;
    else if (roll < 3)
      clock_ms = 32'hFFFF_FFFF - $urandom_range(300);
    else
      clock_ms = clock_ms + $urandom_range(60, 40);
    return clock_ms;
  endfunction

  // Mostly whole press-and-release gestures and combos; the rest is noise.
  function automatic item_t random_item();
    item_t              it;
    logic [LEVEL_W-1:0] r0, r1;
    int                 roll;
    it.now_ms         = advance_clock();
    it.system_state   = ($urandom_range(99) < 75) ? SYS_NORMAL : 2'($urandom_range(3));
    it.wakeup_button  = ($urandom_range(99) < 75) ? '0 : BUTTON_ID_W'($urandom_range(7));
    it.pressed_button = ($urandom_range(99) < 85) ? BUTTON_ID_W'($urandom_range(5, 1))
                                                  : BUTTON_ID_W'($urandom_range(7));
    it.levels         = LEVEL_W'($urandom);
    if (tracker.combo_on && $urandom_range(1) == 1) it.system_state = SYS_WARNING;
    if ($urandom_range(99) < 8) begin
      it.command = CMD_PRESS;
      return it;
    end
    it.command = CMD_POLL;
    if (pattern_left == 0) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        pattern        = SEQ_HOLD;
        pattern_button = $urandom_range(BUTTON_COUNT_DEFAULT - 1);
        pattern_left   = $urandom_range(11, 2);
      end else if (roll < 72) begin
        pattern      = SEQ_COMBO;
        pattern_left = $urandom_range(12, 2);
      end else if (roll < 88) begin
        pattern      = SEQ_OPEN;
        pattern_left = $urandom_range(3, 1);
      end else begin
        pattern      = SEQ_NOISE;
        pattern_left = $urandom_range(3, 1);
      end
    end
    pattern_left--;
    tracker.reset_pair(r0, r1);
    case (pattern)
      SEQ_HOLD:  it.levels = (pattern_left == 0) ? ALL_BUTTONS
                                                 : ~(LEVEL_W'(1) << pattern_button);
      SEQ_COMBO: begin
        if (pattern_left == 0)
          it.levels = ALL_BUTTONS;
        else if ($urandom_range(1) == 1)
          it.levels = ~(r0 | r1);
        else
          it.levels = LEVEL_W'($urandom) & ~(r0 | r1);
      end
      SEQ_OPEN:  it.levels = ALL_BUTTONS;
      default:   it.levels = LEVEL_W'($urandom);
    endcase
    // The factory reset halts the block for good, so it is kept for the end of the run.
    if (tracker.would_halt(it)) it.levels = it.levels | r0;
    return it;
  endfunction

  task automatic offer_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid     <= 1'b1;
    command        <= it.command;
    levels         <= it.levels;
    now_ms         <= it.now_ms;
    system_state   <= it.system_state;
    wakeup_button  <= it.wakeup_button;
    pressed_button <= it.pressed_button;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    tracker.log_item(it);
    items_sent++;
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (tracker.awaited_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic void fill_settings(logic [MS_W-1:0] min_ms, logic [MS_W-1:0] hold,
                                        logic [LEVEL_W-1:0] mask, int cool_lo, int cool_hi);
    settings[REG_MIN_PRESS]  = min_ms;
    settings[REG_RESET_HOLD] = hold;
    // Upper data bits of the mask write are junk that the block must drop.
    settings[REG_RESET_MASK] = {(CFG_DATA_W - LEVEL_W)'($urandom), mask};
    for (int b = 0; b < BUTTON_MAX; b++)
      settings[REG_COOLDOWN_FIRST + b] = CFG_DATA_W'($urandom_range(cool_hi, cool_lo));
  endfunction

  task automatic load_settings();
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_INDEX_W'(i);
      cfg_data  <= settings[i];
      @(posedge clk);
      tracker.write_reg(CFG_INDEX_W'(i), settings[i]);
    end
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [TIME_W-1:0] t;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 38;
    recv_idle_pct = 63;

    // Directed part on reset settings.
    offer_item(item_of(CMD_POLL, ALL_BUTTONS, '0, SYS_NORMAL, '0, '0));
    offer_item(item_of(CMD_POLL, '0, 32'd50, SYS_OTHER, 3'd7, 3'd7));
    offer_item(item_of(CMD_POLL, ALL_BUTTONS, 32'd100, SYS_NORMAL, '0, 3'd1));
    t = 32'd2500;
    // Button one fires; two is the wakeup button; three sees a busy system;
    // four is still cooling down from a simulated press.
    for (int b = 0; b < 4; b++) begin
      if (b == 3) offer_item(item_of(CMD_PRESS, ALL_BUTTONS, t, SYS_NORMAL, '0, 3'd4));
      repeat (4) begin
        t = t + POLL_PERIOD_MS;
        offer_item(item_of(CMD_POLL, ~(LEVEL_W'(1) << b), t, SYS_NORMAL, '0, 3'd1));
      end
      t = t + POLL_PERIOD_MS;
      offer_item(item_of(CMD_POLL, ALL_BUTTONS, t, (b == 2) ? SYS_BUSY : SYS_NORMAL,
                         (b == 1) ? 3'd2 : 3'd0, 3'd1));
    end
    offer_item(item_of(CMD_PRESS, ALL_BUTTONS, t, SYS_NORMAL, '0, 3'd0));
    offer_item(item_of(CMD_PRESS, ALL_BUTTONS, t, SYS_NORMAL, '0, 3'd6));
    offer_item(item_of(CMD_PRESS, '0, 32'hFFFF_FFFF, SYS_WARNING, 3'd5, 3'd5));
    clock_ms = t;
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: fill_settings(16'd200, 16'd400, 5'b00011, 0, 300);
        1: fill_settings(16'd0, 16'd0, 5'b11111, 65535, 65535);
        2: fill_settings(MS_W'($urandom_range(600)), 16'd3000, 5'b00100, 0, 3000);
        3: fill_settings(16'd100, 16'd1, 5'b11000, 100, 100);
        4: fill_settings(16'd50, 16'd3001, 5'b01001, 0, 0);
        default: fill_settings(16'd150, 16'd60000, 5'b10110, 0, 65535);
      endcase
      load_settings();
      send_idle_pct = (phase < 2) ? 38 : (phase < 4) ? 63 : 0;
      recv_idle_pct = (phase < 2) ? 63 : (phase < 4) ? 38 : 0;
      if (phase == 4) hold_off_pending = 1'b1;
      repeat (PHASE_ITEMS) offer_item(random_item());
      settle();
    end

    // Hold button five for a long stretch that just reaches a large minimum press time.
    fill_settings(16'd10000, 16'd8000, 5'b00000, 0, 0);
    load_settings();
    repeat (200) begin
      clock_ms = clock_ms + POLL_PERIOD_MS;
      offer_item(item_of(CMD_POLL, 5'b01111, clock_ms, SYS_NORMAL, '0, 3'd1));
    end
    clock_ms = clock_ms + POLL_PERIOD_MS;
    offer_item(item_of(CMD_POLL, ALL_BUTTONS, clock_ms, SYS_NORMAL, '0, 3'd1));
    settle();

    // Hold the combo through the warning into the factory reset, then show the halt.
    fill_settings(16'd200, 16'd400, 5'b00011, 2000, 2000);
    load_settings();
    repeat (10) begin
      clock_ms = clock_ms + POLL_PERIOD_MS;
      offer_item(item_of(CMD_POLL, 5'b11100, clock_ms, SYS_NORMAL, '0, 3'd1));
    end
    repeat (6) offer_item(random_item());
    settle();

    $display("Checked %0d results from %0d items on the reset settings and eight loaded ones.",
             tracker.checked, items_sent);
    $display("Expected fires %0d, warnings %0d, returns to normal %0d, factory resets %0d.",
             tracker.fires, tracker.warnings, tracker.returns, tracker.halts);
    if (tracker.errors == 0 && tracker.awaited_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
